// File: hdl/tqm_pkg.sv
package tqm_pkg;

	localparam int ID_W       = 32;
	localparam int TIME_W     = 32;
	localparam int INTV_W     = 24;
	localparam int OPC_W      = 2;
	localparam int STAT_W     = 3;
	localparam int CNT_OUT_W  = 5;
	localparam int TIMERS_DEF = 16;

	// opcodes
	localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPC_W-1:0] OP_SCHED  = 2'd1;
	localparam logic [OPC_W-1:0] OP_CANCEL = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_SCHEDULED = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd3;
	localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] deadline;
	} entry_t;

endpackage

// File: hdl/tqm_req_if.sv
interface tqm_req_if;
	logic                        valid;
	logic                        ready;
	logic [tqm_pkg::OPC_W-1:0]   opcode;
	logic [tqm_pkg::INTV_W-1:0]  interval;
	logic [tqm_pkg::ID_W-1:0]    cancel_id;

	modport source (output valid, output opcode, output interval, output cancel_id,
		input ready);
	modport sink (input valid, input opcode, input interval, input cancel_id,
		output ready);
endinterface

// File: hdl/tqm_rsp_if.sv
interface tqm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tqm_pkg::STAT_W-1:0]     status;
	logic [tqm_pkg::ID_W-1:0]       tmr_id;
	logic [tqm_pkg::CNT_OUT_W-1:0]  active_count;
	logic                           last;

	modport source (output valid, output status, output tmr_id, output active_count,
		output last, input ready);
	modport sink (input valid, input status, input tmr_id, input active_count,
		input last, output ready);
endinterface

// File: hdl/tqm_cell.sv
// One timer slot of the ring; takes its neighbor's entry on each shift.
module tqm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  tqm_pkg::entry_t d,
	output tqm_pkg::entry_t q
);

	logic                       valid_q;
	logic [tqm_pkg::ID_W-1:0]   id_q;
	logic [tqm_pkg::TIME_W-1:0] deadline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			id_q       <= d.id;
			deadline_q <= d.deadline;
		end
	end

	assign q = '{valid: valid_q, id: id_q, deadline: deadline_q};

endmodule

// File: hdl/timer_queue_manager_core.sv
// Timer queue manager: a table of TIMERS one-shot timers.
// req channel (sink): opcode tick / schedule / cancel, with interval and cancel_id.
// rsp channel (source): status, tmr_id, active_count and last, one beat per result.
// Schedule and cancel give one beat. A tick gives one beat per due timer, earliest
// deadline first (lower id on equal deadlines), or one "nothing expired" beat.
// The last beat of every command has last = 1. Opcode 3 is taken and dropped.
// The slots live in a ring of cells that rotates by one position per cycle while a
// pass is running; the controller looks at the head cell only, so one full pass
// visits every slot once and leaves the ring in its original order.
// On a tick, each pass finds the next due timer while freeing the one found by the
// pass before it.
// req.ready is high only while no command is in progress; a finished beat parked
// in the output register does not hold off the next command.
// Reset clears time, next id, counts and all slot valid bits; no clearing pass.
// A stalled rsp holds the beat in the output register and the sequencer waits.
module timer_queue_manager_core #(
	parameter int TIMERS = tqm_pkg::TIMERS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tqm_req_if.sink   req,
	tqm_rsp_if.source rsp
);

	localparam int IW = $clog2(TIMERS);
	localparam int CW = $clog2(TIMERS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	// ---------------------------------------------------------------- ring
	tqm_pkg::entry_t cell_out [TIMERS];
	tqm_pkg::entry_t head_new;
	logic [TIMERS-1:0] vld;
	logic shift;

	for (genvar j = 0; j < TIMERS; j++) begin : g_cell
		tqm_pkg::entry_t cin;
		if (j == TIMERS - 1) begin : g_tail
			assign cin = head_new;
		end else begin : g_mid
			assign cin = cell_out[j+1];
		end
		tqm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (cin),
			.q      (cell_out[j])
		);
		assign vld[j] = cell_out[j].valid;
	end

	// ---------------------------------------------------------------- control state
	logic [1:0]                  state_q;
	logic [IW-1:0]               step_q;
	logic [tqm_pkg::OPC_W-1:0]   op_q;
	logic [tqm_pkg::ID_W-1:0]    arg_id_q;
	logic [tqm_pkg::TIME_W-1:0]  dl_q;
	logic [tqm_pkg::TIME_W-1:0]  time_q;
	logic [tqm_pkg::ID_W-1:0]    next_id_q;
	logic [CW-1:0]               count_q;
	logic                        hit_q;
	// best due candidate of the current pass
	logic                        found_q;
	logic [tqm_pkg::TIME_W-1:0]  best_age_q;
	logic [tqm_pkg::ID_W-1:0]    best_id_q;
	logic [IW-1:0]               best_idx_q;
	// timer found by the previous pass, freed during this one
	logic                        pend_q;
	logic [tqm_pkg::ID_W-1:0]    pend_id_q;
	logic [IW-1:0]               pend_idx_q;
	// result staged for the output register
	logic [tqm_pkg::STAT_W-1:0]  res_status_q;
	logic [tqm_pkg::ID_W-1:0]    res_id_q;
	logic                        res_last_q;
	// output register
	logic                        out_valid_q;
	logic [tqm_pkg::STAT_W-1:0]  out_status_q;
	logic [tqm_pkg::ID_W-1:0]    out_id_q;
	logic [tqm_pkg::CNT_OUT_W-1:0] out_count_q;
	logic                        out_last_q;

	// ---------------------------------------------------------------- head cell logic
	tqm_pkg::entry_t            head;
	logic [tqm_pkg::TIME_W-1:0] age;
	logic                       due;
	logic                       clr_hit;
	logic                       take;
	logic                       better;
	logic                       accept;
	logic                       load_out;

	assign head    = cell_out[0];
	assign shift   = (state_q == S_SCAN);
	assign age     = time_q - head.deadline;
	assign due     = head.valid && !age[tqm_pkg::TIME_W-1];
	assign clr_hit = (op_q == tqm_pkg::OP_TICK) && pend_q && (step_q == pend_idx_q);

	always_comb begin
		head_new = head;
		take     = 1'b0;
		better   = 1'b0;
		case (op_q)
			tqm_pkg::OP_SCHED: begin
				if (!hit_q && !head.valid) begin
					head_new = '{valid: 1'b1, id: next_id_q, deadline: dl_q};
					take     = 1'b1;
				end
			end
			tqm_pkg::OP_CANCEL: begin
				if (!hit_q && head.valid && head.id == arg_id_q) begin
					head_new.valid = 1'b0;
					take           = 1'b1;
				end
			end
			tqm_pkg::OP_TICK: begin
				if (clr_hit) begin
					head_new.valid = 1'b0;
				end
				better = due && !clr_hit && (!found_q || age > best_age_q ||
					(age == best_age_q && head.id < best_id_q));
			end
			default: begin
			end
		endcase
	end

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			op_q       <= tqm_pkg::OP_TICK;
			time_q     <= '0;
			next_id_q  <= '0;
			count_q    <= '0;
			hit_q      <= 1'b0;
			found_q    <= 1'b0;
			pend_q     <= 1'b0;
			res_last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req.opcode;
						step_q  <= '0;
						hit_q   <= 1'b0;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						if (req.opcode == tqm_pkg::OP_TICK) begin
							time_q <= time_q + 1'b1;
						end
						if (req.opcode == tqm_pkg::OP_TICK || req.opcode == tqm_pkg::OP_SCHED
							|| req.opcode == tqm_pkg::OP_CANCEL) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					step_q <= step_q + 1'b1;
					if (take) begin
						hit_q <= 1'b1;
					end
					if (better) begin
						found_q <= 1'b1;
					end
					if (step_q == IW'(TIMERS - 1)) begin
						step_q  <= '0;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q    <= S_EMIT;
					res_last_q <= 1'b1;
					case (op_q)
						tqm_pkg::OP_SCHED: begin
							if (hit_q) begin
								next_id_q <= next_id_q + 1'b1;
								count_q   <= count_q + 1'b1;
							end
						end
						tqm_pkg::OP_CANCEL: begin
							if (hit_q) begin
								count_q <= count_q - 1'b1;
							end
						end
						default: begin
							if (pend_q) begin
								// previous timer was freed in this pass
								count_q    <= count_q - 1'b1;
								res_last_q <= !found_q;
								pend_q     <= found_q;
							end else if (found_q) begin
								// first due timer found; free it on the next pass
								pend_q  <= 1'b1;
								found_q <= 1'b0;
								state_q <= S_SCAN;
							end
						end
					endcase
				end
				S_EMIT: begin
					if (load_out) begin
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SCAN;
							found_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			arg_id_q <= req.cancel_id;
			dl_q     <= time_q + tqm_pkg::TIME_W'(req.interval);
		end
		if (state_q == S_SCAN && better) begin
			best_age_q <= age;
			best_id_q  <= head.id;
			best_idx_q <= step_q;
		end
		if (state_q == S_EVAL) begin
			case (op_q)
				tqm_pkg::OP_SCHED: begin
					res_status_q <= hit_q ? tqm_pkg::ST_SCHEDULED : tqm_pkg::ST_FULL;
					res_id_q     <= hit_q ? next_id_q : '0;
				end
				tqm_pkg::OP_CANCEL: begin
					res_status_q <= hit_q ? tqm_pkg::ST_CANCELLED : tqm_pkg::ST_NOTFOUND;
					res_id_q     <= hit_q ? arg_id_q : '0;
				end
				default: begin
					res_status_q <= pend_q ? tqm_pkg::ST_EXPIRED : tqm_pkg::ST_NONE;
					res_id_q     <= pend_q ? pend_id_q : '0;
					pend_id_q    <= best_id_q;
					pend_idx_q   <= best_idx_q;
				end
			endcase
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_count_q  <= tqm_pkg::CNT_OUT_W'(count_q);
			out_last_q   <= res_last_q;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.tmr_id       = out_id_q;
	assign rsp.active_count = out_count_q;
	assign rsp.last         = out_last_q;

`ifndef SYNTHESIS
	// pending count tracks the ring's valid bits whenever no command runs
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(vld) == int'(count_q)))
		else $error("pending count does not match valid slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= TIMERS)
		else $error("pending count above table size");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == tqm_pkg::OP_TICK) |=> (time_q == $past(time_q) + 1'b1))
		else $error("tick did not advance time");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == tqm_pkg::ST_NONE) |-> (rsp.last && rsp.tmr_id == '0))
		else $error("nothing-expired beat malformed");

	a_ring_still: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !accept) |=> $stable(vld))
		else $error("slot valid bits changed while idle");
`endif

endmodule
